// ----- rtl/sie_pkg.sv -----
// ----------------------------------------------------------------------------
// sie_pkg
// Shared types and codes for the 16-bit instruction executor.
// ----------------------------------------------------------------------------
package sie_pkg;

    localparam int MEM_ADDR_BITS_DEF = 16;

    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_BL   = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    localparam logic [2:0] BR_Z   = 3'd0;
    localparam logic [2:0] BR_NZ  = 3'd1;
    localparam logic [2:0] BR_N   = 3'd2;
    localparam logic [2:0] BR_P   = 3'd3;
    localparam logic [2:0] BR_AL  = 3'd7;

    localparam logic [7:0] TV_HALT  = 8'd0;
    localparam logic [7:0] TV_NL    = 8'd1;
    localparam logic [7:0] TV_PRINT = 8'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_NL      = 3'd1;
    localparam logic [2:0] EV_PRINT   = 3'd2;
    localparam logic [2:0] EV_HALT    = 3'd3;
    localparam logic [2:0] EV_BADBR   = 3'd4;
    localparam logic [2:0] EV_HALTED  = 3'd5;

    localparam logic ACT_LOAD = 1'b0;

    typedef struct packed {
        logic        action;
        logic [15:0] load_address;
        logic [15:0] load_word;
    } item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_LOAD
    } state_t;

endpackage

// ----- rtl/sie_ram.sv -----
// ----------------------------------------------------------------------------
// sie_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module sie_ram #(
    parameter int WIDTH = 16,
    parameter int ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [WIDTH-1:0]     wdata,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end
endmodule

// ----- rtl/sie_front.sv -----
// ----------------------------------------------------------------------------
// sie_front
// Input acceptance and a two-entry queue toward the execution side.
// ----------------------------------------------------------------------------
module sie_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sie_pkg::item_t in_item,
    output logic          q_valid,
    output sie_pkg::item_t q_item,
    input  logic          q_pop
);
    import sie_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

// ----- rtl/sie_back.sv -----
// ----------------------------------------------------------------------------
// sie_back
// Execution side: memory clear, fetch, decode, execute, result register.
// ----------------------------------------------------------------------------
module sie_back #(
    parameter int MEM_ADDR_BITS = sie_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  sie_pkg::item_t q_item,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    event_res,
    output logic signed [15:0] print_value,
    output logic [15:0]   next_pc,
    output logic [3:0]    flag_bits
);
    import sie_pkg::*;

    localparam int A = MEM_ADDR_BITS;

    state_t      state_reg, state_next;
    logic [A-1:0] clr_reg, clr_next;
    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg, pc_next;
    logic [3:0]  fl_reg, fl_next;
    logic        halt_reg, halt_next;
    logic [2:0]  dr_reg, dr_next;

    logic        rf_we;
    logic [2:0]  rf_waddr;
    logic [15:0] rf_wdata;

    logic         ram_we;
    logic [A-1:0] ram_addr;
    logic [15:0]  ram_wdata, ram_rdata;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  ev_reg;
    logic [15:0] pv_reg, opc_reg;
    logic [3:0]  ofl_reg;
    logic        fire;
    logic [2:0]  ev_val;
    logic [15:0] pv_val;

    logic        slot_free;
    logic [15:0] ir, pc1, off9, off11, off6, imm5, base, opnd, sum16, res, dbase;
    logic [16:0] full;
    logic [3:0]  op;
    logic [2:0]  dr, sr1, sr2;
    logic        take;

    sie_ram #(.WIDTH(16), .ADDR_BITS(A)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign slot_free   = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign print_value = pv_reg;
    assign next_pc     = opc_reg;
    assign flag_bits   = ofl_reg;

    assign ir    = ram_rdata;
    assign op    = ir[15:12];
    assign dr    = ir[11:9];
    assign sr1   = ir[8:6];
    assign sr2   = ir[2:0];
    assign pc1   = pc_reg + 16'd1;
    assign off9  = {{7{ir[8]}}, ir[8:0]};
    assign off11 = {{5{ir[10]}}, ir[10:0]};
    assign off6  = {{10{ir[5]}}, ir[5:0]};
    assign imm5  = {{11{ir[4]}}, ir[4:0]};
    assign opnd  = ir[5] ? imm5 : rf_reg[sr2];
    assign full  = {1'b0, rf_reg[sr1]} + {1'b0, opnd};
    assign sum16 = full[15:0];
    // blr through r7 sees the freshly written return address
    assign base  = (sr1 == 3'd7) ? pc1 : rf_reg[sr1];
    assign dbase = rf_reg[sr1] + off6;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        fl_next    = fl_reg;
        halt_next  = halt_reg;
        dr_next    = dr_reg;
        rf_we      = 1'b0;
        rf_waddr   = dr;
        rf_wdata   = 16'd0;
        ram_we     = 1'b0;
        ram_addr   = pc_reg[A-1:0];
        ram_wdata  = 16'd0;
        q_pop      = 1'b0;
        fire       = 1'b0;
        ev_val     = EV_NONE;
        pv_val     = 16'd0;
        take       = 1'b0;
        res        = 16'd0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    if (q_item.action == ACT_LOAD)
                    begin
                        ram_we    = 1'b1;
                        ram_addr  = q_item.load_address[A-1:0];
                        ram_wdata = q_item.load_word;
                        fire      = 1'b1;
                    end
                    else if (halt_reg)
                    begin
                        fire   = 1'b1;
                        ev_val = EV_HALTED;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                pc_next    = pc1;
                fire       = 1'b1;
                state_next = ST_IDLE;
                case (op)
                    OP_BR:
                    begin
                        case (dr)
                            BR_Z:    take = fl_reg[2];
                            BR_NZ:   take = !fl_reg[2];
                            BR_N:    take = fl_reg[3];
                            BR_P:    take = (fl_reg[3] == fl_reg[2]);
                            BR_AL:   take = 1'b1;
                            default: ev_val = EV_BADBR;
                        endcase
                        if (take)
                        begin
                            pc_next = pc1 + off9;
                        end
                    end
                    OP_ADD:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = sum16;
                        fl_next  = {sum16[15], sum16 == 16'd0, full[16],
                            (rf_reg[sr1][15] ^ sum16[15]) & (opnd[15] ^ sum16[15])};
                    end
                    OP_LD, OP_LDR:
                    begin
                        fire       = 1'b0;
                        dr_next    = dr;
                        state_next = ST_LOAD;
                        ram_addr   = (op == OP_LD) ? (pc1[A-1:0] + off9[A-1:0])
                                                   : dbase[A-1:0];
                    end
                    OP_ST, OP_STR:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = rf_reg[dr];
                        ram_addr  = (op == OP_ST) ? (pc1[A-1:0] + off9[A-1:0])
                                                  : dbase[A-1:0];
                    end
                    OP_BL:
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = 3'd7;
                        rf_wdata = pc1;
                        pc_next  = ir[11] ? (pc1 + off11) : (base + off6);
                    end
                    OP_AND, OP_NOT:
                    begin
                        res      = (op == OP_AND) ? (rf_reg[sr1] & opnd) : ~rf_reg[sr1];
                        rf_we    = 1'b1;
                        rf_wdata = res;
                        fl_next  = {res[15], res == 16'd0, fl_reg[1:0]};
                    end
                    OP_JMP:
                    begin
                        pc_next = dbase;
                    end
                    OP_LEA:
                    begin
                        rf_we    = 1'b1;
                        rf_wdata = pc1 + off9;
                    end
                    OP_TRAP:
                    begin
                        case (ir[7:0])
                            TV_HALT:
                            begin
                                halt_next = 1'b1;
                                ev_val    = EV_HALT;
                            end
                            TV_NL:    ev_val = EV_NL;
                            TV_PRINT:
                            begin
                                ev_val = EV_PRINT;
                                pv_val = rf_reg[dr];
                            end
                            default:  ev_val = EV_NONE;
                        endcase
                    end
                    default:
                    begin
                        ev_val = EV_NONE;
                    end
                endcase
            end
            ST_LOAD:
            begin
                rf_we      = 1'b1;
                rf_waddr   = dr_reg;
                rf_wdata   = ram_rdata;
                fire       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= 16'd0;
            fl_reg        <= 4'd0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            fl_reg        <= fl_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
            if (rf_we)
            begin
                rf_reg[rf_waddr] <= rf_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg <= dr_next;
        if (fire)
        begin
            ev_reg  <= ev_val;
            pv_reg  <= pv_val;
            opc_reg <= pc_next;
            ofl_reg <= fl_next;
        end
    end
endmodule

// ----- rtl/lcc_subset_instruction_executor_top.sv -----
// ----------------------------------------------------------------------------
// Instruction executor top
// 16-bit processor core: word loads and single-instruction steps.
// ----------------------------------------------------------------------------
// Channel | Signals                                   | Direction
// in      | in_valid/in_ready, action, load_address,  | item in
//         | load_word                                 |
// out     | out_valid/out_ready, event_res,           | one result per item
//         | print_value, next_pc, flag_bits           |
//
// A load item is written to memory as it is taken; a step goes through fetch
// and, with ld/ldr, a load state, set by the single memory port (fetch, then
// data access). After reset the memory is cleared before any item is
// executed; the input queue still takes two items meanwhile.
// A two-entry queue decouples input from execution; the result register
// holds while out_ready is low.
// ----------------------------------------------------------------------------
module lcc_subset_instruction_executor_top #(
    parameter int MEM_ADDR_BITS = sie_pkg::MEM_ADDR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [15:0]        load_address,
    input  logic [15:0]        load_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         event_res,
    output logic signed [15:0] print_value,
    output logic [15:0]        next_pc,
    output logic [3:0]         flag_bits
);
    import sie_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_pop;

    assign in_item = '{action: action, load_address: load_address, load_word: load_word};

    sie_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sie_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .print_value (print_value),
        .next_pc     (next_pc),
        .flag_bits   (flag_bits)
    );
endmodule
